/* sv/tcg_pkg.sv */
// ----------------------------------------------------------------------------
// tcg_pkg: shared definitions for the text console cell grid
// Field widths, register indexes, character codes, action codes and the
// result bundle handed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tcg_pkg;

  // Grid size defaults
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 128;

  // Payload field widths
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int TCOL_W   = 8;
  localparam int TROW_W   = 7;
  localparam int CELL_W   = CHAR_W + 2 * COLOR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COLS_REG_W = 9;
  localparam int ROWS_REG_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;

  localparam int COLS_RESET = 80;
  localparam int ROWS_RESET = 25;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Colors of a blank cell after reset
  localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

  // Actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_MOVE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // One result item
  typedef struct packed {
    logic [TCOL_W-1:0]  cursor_col;
    logic [TROW_W-1:0]  cursor_row;
    logic               scrolled;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_fg;
    logic [COLOR_W-1:0] cell_bg;
  } res_t;

endpackage

`default_nettype wire

/* sv/tcg_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tcg_cfg_regs: grid size registers
// Takes register writes and keeps the index of the last active column and
// row, with zero and out-of-range sizes folded into the legal range.
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_cfg_regs #(
  parameter int MAX_COLS = tcg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcg_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_write,
  input  wire logic [tcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tcg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic      [$clog2(MAX_COLS)-1:0]     last_col,
  output logic      [$clog2(MAX_ROWS)-1:0]     last_row
);
  import tcg_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  // Last usable index for a size value: zero acts as one, large values cap
  function automatic int last_index(int value, int limit);
    int res;
    if (value == 0) begin
      res = 0;
    end else if (value > limit) begin
      res = limit - 1;
    end else begin
      res = value - 1;
    end
    return res;
  endfunction

  logic [CW-1:0] last_col_r, last_col_nxt;
  logic [RW-1:0] last_row_r, last_row_nxt;

  // Decode the register index of a write transfer
  always_comb begin
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: begin
          last_col_nxt = CW'(last_index(int'(cfg_data[COLS_REG_W-1:0]), MAX_COLS));
        end
        REG_ROWS: begin
          last_row_nxt = RW'(last_index(int'(cfg_data[ROWS_REG_W-1:0]), MAX_ROWS));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= CW'(last_index(COLS_RESET, MAX_COLS));
      last_row_r <= RW'(last_index(ROWS_RESET, MAX_ROWS));
    end else begin
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  assign last_col = last_col_r;
  assign last_row = last_row_r;

endmodule

`default_nettype wire

/* sv/tcg_seq.sv */
// ----------------------------------------------------------------------------
// tcg_seq: cell store and action sequencer
// Holds the cell memory and the cursor. A small state machine drives one
// memory write port and one read port: single cell updates, the row-by-row
// scroll copy, bottom row blanking, the clear sweep and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_seq #(
  parameter int MAX_COLS = tcg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcg_pkg::MAX_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcg_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [tcg_pkg::CHAR_W-1:0]    in_char_code,
  input  wire logic [tcg_pkg::COLOR_W-1:0]   in_fg_color,
  input  wire logic [tcg_pkg::COLOR_W-1:0]   in_bg_color,
  input  wire logic [tcg_pkg::TCOL_W-1:0]    in_target_col,
  input  wire logic [tcg_pkg::TROW_W-1:0]    in_target_row,
  input  wire logic [$clog2(MAX_COLS)-1:0]   last_col,
  input  wire logic [$clog2(MAX_ROWS)-1:0]   last_row,
  input  wire logic                          res_free,
  output logic                               res_valid,
  output tcg_pkg::res_t                      res
);
  import tcg_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCROLL,
    S_DRAIN,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

  // Cell memory, addressed as {row, column}
  logic [CELL_W-1:0] mem [0:DEPTH-1];
  logic [CELL_W-1:0] rdata_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  state_t             state_r, state_nxt;
  action_t            act_r, act_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic [TCOL_W-1:0]  tcol_r, tcol_nxt;
  logic [TROW_W-1:0]  trow_r, trow_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt;
  logic [RW-1:0]      cur_row_r, cur_row_nxt;
  logic               scrolled_r, scrolled_nxt;
  logic [CELL_W-1:0]  rcell_r, rcell_nxt;
  logic [CW-1:0]      col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]      row_cnt_r, row_cnt_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic               copy_pend_r, copy_pend_nxt;
  logic [AW-1:0]      copy_addr_r, copy_addr_nxt;

  logic [CELL_W-1:0]  blank_cell;
  logic [CELL_W-1:0]  init_cell;
  logic [CW-1:0]      tcol_clamp;
  logic [RW-1:0]      trow_clamp;
  logic [RW-1:0]      row_cnt_inc;
  logic [CW-1:0]      cur_col_dec;
  logic               adv_row;
  logic               accept;

  assign blank_cell  = {CH_SPACE, fg_r, bg_r};
  assign init_cell   = {CH_SPACE, RESET_FG, RESET_BG};
  assign row_cnt_inc = row_cnt_r + RW'(1);
  assign cur_col_dec = cur_col_r - CW'(1);
  assign accept      = in_valid && !in_stall;

  // Clamp move and read targets to the last active column and row
  always_comb begin
    if (32'(tcol_r) > 32'(last_col)) begin
      tcol_clamp = last_col;
    end else begin
      tcol_clamp = CW'(tcol_r);
    end
    if (32'(trow_r) > 32'(last_row)) begin
      trow_clamp = last_row;
    end else begin
      trow_clamp = RW'(trow_r);
    end
  end

  // Sequencer and memory port control
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    ch_nxt        = ch_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    tcol_nxt      = tcol_r;
    trow_nxt      = trow_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scrolled_nxt  = scrolled_r;
    rcell_nxt     = rcell_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    sweep_nxt     = sweep_r;
    copy_pend_nxt = 1'b0;
    copy_addr_nxt = copy_addr_r;
    adv_row       = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    res_valid     = 1'b0;

    // Finish a scroll copy in the cycle after its read
    mem_we    = copy_pend_r;
    mem_waddr = copy_addr_r;
    mem_wdata = rdata_r;

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = init_cell;
        sweep_nxt = sweep_r + AW'(1);
        if (&sweep_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Keep the cursor inside a grid that was just shrunk
        if (cur_col_r > last_col) begin
          cur_col_nxt = last_col;
        end
        if (cur_row_r > last_row) begin
          cur_row_nxt = last_row;
        end
        if (accept) begin
          act_nxt      = action_t'(in_action);
          ch_nxt       = in_char_code;
          fg_nxt       = in_fg_color;
          bg_nxt       = in_bg_color;
          tcol_nxt     = in_target_col;
          trow_nxt     = in_target_row;
          scrolled_nxt = 1'b0;
          rcell_nxt    = '0;
          state_nxt    = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (act_r)
          ACT_PUT: begin
            case (ch_r)
              CH_NEWLINE: begin
                cur_col_nxt = '0;
                adv_row     = 1'b1;
              end
              CH_RETURN: begin
                cur_col_nxt = '0;
              end
              CH_BACKSPACE: begin
                if (cur_col_r != '0) begin
                  cur_col_nxt = cur_col_dec;
                  mem_we      = 1'b1;
                  mem_waddr   = {cur_row_r, cur_col_dec};
                  mem_wdata   = blank_cell;
                end
              end
              default: begin
                mem_we    = 1'b1;
                mem_waddr = {cur_row_r, cur_col_r};
                mem_wdata = {ch_r, fg_r, bg_r};
                if (cur_col_r == last_col) begin
                  cur_col_nxt = '0;
                  adv_row     = 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r + CW'(1);
                end
              end
            endcase
            state_nxt = S_DONE;
            if (adv_row) begin
              if (cur_row_r == last_row) begin
                // Past the bottom: scroll up, cursor stays on the last row
                scrolled_nxt = 1'b1;
                col_cnt_nxt  = '0;
                row_cnt_nxt  = '0;
                state_nxt    = (last_row == '0) ? S_BLANK : S_SCROLL;
              end else begin
                cur_row_nxt = cur_row_r + RW'(1);
              end
            end
          end
          ACT_MOVE: begin
            cur_col_nxt = tcol_clamp;
            cur_row_nxt = trow_clamp;
            state_nxt   = S_DONE;
          end
          ACT_CLEAR: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            sweep_nxt   = '0;
            state_nxt   = S_CLEAR;
          end
          ACT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = {trow_clamp, tcol_clamp};
            state_nxt = S_RDWAIT;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_RDWAIT: begin
        rcell_nxt = rdata_r;
        state_nxt = S_DONE;
      end

      S_SCROLL: begin
        // Read the cell one row down, write it back on the next cycle
        mem_re        = 1'b1;
        mem_raddr     = {row_cnt_inc, col_cnt_r};
        copy_pend_nxt = 1'b1;
        copy_addr_nxt = {row_cnt_r, col_cnt_r};
        if (col_cnt_r == last_col) begin
          col_cnt_nxt = '0;
          if (row_cnt_inc == last_row) begin
            state_nxt = S_DRAIN;
          end else begin
            row_cnt_nxt = row_cnt_inc;
          end
        end else begin
          col_cnt_nxt = col_cnt_r + CW'(1);
        end
      end

      S_DRAIN: begin
        col_cnt_nxt = '0;
        state_nxt   = S_BLANK;
      end

      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {last_row, col_cnt_r};
        mem_wdata = blank_cell;
        if (col_cnt_r == last_col) begin
          state_nxt = S_DONE;
        end else begin
          col_cnt_nxt = col_cnt_r + CW'(1);
        end
      end

      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = blank_cell;
        sweep_nxt = sweep_r + AW'(1);
        if (&sweep_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over once the output stage has room
        res_valid = 1'b1;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, cursor and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      copy_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      copy_pend_r <= copy_pend_nxt;
    end
    act_r       <= act_nxt;
    ch_r        <= ch_nxt;
    fg_r        <= fg_nxt;
    bg_r        <= bg_nxt;
    tcol_r      <= tcol_nxt;
    trow_r      <= trow_nxt;
    scrolled_r  <= scrolled_nxt;
    rcell_r     <= rcell_nxt;
    col_cnt_r   <= col_cnt_nxt;
    row_cnt_r   <= row_cnt_nxt;
    copy_addr_r <= copy_addr_nxt;
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    res.cursor_col = TCOL_W'(cur_col_r);
    res.cursor_row = TROW_W'(cur_row_r);
    res.scrolled   = scrolled_r;
    res.cell_char  = rcell_r[CELL_W-1 -: CHAR_W];
    res.cell_fg    = rcell_r[2*COLOR_W-1 -: COLOR_W];
    res.cell_bg    = rcell_r[COLOR_W-1:0];
  end

endmodule

`default_nettype wire

/* sv/text_console_cell_grid_core.sv */
// Flow: a put or move passes through execute and done; a read adds a read-wait state;
// a scrolling put adds the row copy (when rows > 1) and the bottom row blanking,
// and clear adds a sweep over all 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells.
// Throughput: one item at a time; a new item is taken only after the last result is handed over.
// Reset: cursor homes, grid size returns to 80x25, and a clearing pass over all
// 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells (32768 by default) blanks the store.
// ----------------------------------------------------------------------------
// text_console_cell_grid_core: text console cell grid
// Character grid with cursor, line wrap, scroll, clear and cell read-back,
// with a result register on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_grid_core #(
  parameter int MAX_COLS = tcg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tcg_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tcg_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [tcg_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic [tcg_pkg::COLOR_W-1:0]    in_fg_color,
  input  wire logic [tcg_pkg::COLOR_W-1:0]    in_bg_color,
  input  wire logic [tcg_pkg::TCOL_W-1:0]     in_target_col,
  input  wire logic [tcg_pkg::TROW_W-1:0]     in_target_row,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tcg_pkg::TCOL_W-1:0]     out_cursor_col,
  output logic      [tcg_pkg::TROW_W-1:0]     out_cursor_row,
  output logic                                out_scrolled,
  output logic      [tcg_pkg::CHAR_W-1:0]     out_cell_char,
  output logic      [tcg_pkg::COLOR_W-1:0]    out_cell_fg,
  output logic      [tcg_pkg::COLOR_W-1:0]    out_cell_bg,
  // Configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcg_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic          res_valid;
  logic          res_free;
  res_t          res;

  logic          out_valid_r, out_valid_nxt;
  res_t          out_res_r, out_res_nxt;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  tcg_cfg_regs #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .last_col  (last_col),
    .last_row  (last_row)
  );

  tcg_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_fg_color   (in_fg_color),
    .in_bg_color   (in_bg_color),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .last_col      (last_col),
    .last_row      (last_row),
    .res_free      (res_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register: load a new result when the slot is empty or draining
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_res_r.cursor_col;
  assign out_cursor_row = out_res_r.cursor_row;
  assign out_scrolled   = out_res_r.scrolled;
  assign out_cell_char  = out_res_r.cell_char;
  assign out_cell_fg    = out_res_r.cell_fg;
  assign out_cell_bg    = out_res_r.cell_bg;

endmodule

`default_nettype wire

/* dv/tb_text_console_cell_grid_core.sv */
// ----------------------------------------------------------------------------
// tb_text_console_cell_grid_core: self-checking bench for the cell grid core
// Sends put, move, clear and read operations through several grid sizes and
// idle patterns. A shadow grid predicts the cursor, the scroll flag and the
// read-back cell for every operation, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_text_console_cell_grid_core;
  import tcg_pkg::*;

  localparam int GRID_COLS_MAX = MAX_COLS_DEF;
  localparam int GRID_ROWS_MAX = MAX_ROWS_DEF;
  localparam int QUIET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct {
    action_t            act;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [TCOL_W-1:0]  tcol;
    logic [TROW_W-1:0]  trow;
    bit                 hold;
  } console_op_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action     = '0;
  logic [CHAR_W-1:0]     in_char_code  = '0;
  logic [COLOR_W-1:0]    in_fg_color   = '0;
  logic [COLOR_W-1:0]    in_bg_color   = '0;
  logic [TCOL_W-1:0]     in_target_col = '0;
  logic [TROW_W-1:0]     in_target_row = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [TCOL_W-1:0]     out_cursor_col;
  logic [TROW_W-1:0]     out_cursor_row;
  logic                  out_scrolled;
  logic [CHAR_W-1:0]     out_cell_char;
  logic [COLOR_W-1:0]    out_cell_fg;
  logic [COLOR_W-1:0]    out_cell_bg;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Shadow of the console: cells, grid registers and cursor
  logic [CELL_W-1:0]     shadow_cells [GRID_COLS_MAX*GRID_ROWS_MAX];
  logic [COLS_REG_W-1:0] cols_reg;
  logic [ROWS_REG_W-1:0] rows_reg;
  int                    cur_col;
  int                    cur_row;

  console_op_t op_q[$];
  res_t        status_q[$];
  console_op_t drv_op;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int results_pending = 0;
  int clears_left     = 4;
  int n_errors        = 0;
  int n_sent          = 0;
  int n_clears        = 0;
  int n_results       = 0;
  int n_scrolls       = 0;
  int n_reg_writes    = 0;
  int n_settings      = 1;

  text_console_cell_grid_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_fg_color   (in_fg_color),
    .in_bg_color   (in_bg_color),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_scrolled  (out_scrolled),
    .out_cell_char (out_cell_char),
    .out_cell_fg   (out_cell_fg),
    .out_cell_bg   (out_cell_bg),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Effective grid size: zero acts as one, oversize acts as the maximum
  function automatic int grid_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > GRID_COLS_MAX) return GRID_COLS_MAX;
    return int'(cols_reg);
  endfunction

  function automatic int grid_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > GRID_ROWS_MAX) return GRID_ROWS_MAX;
    return int'(rows_reg);
  endfunction

  function automatic void clamp_cursor();
    if (cur_col >= grid_cols()) cur_col = grid_cols() - 1;
    if (cur_row >= grid_rows()) cur_row = grid_rows() - 1;
  endfunction

  // Apply one operation to the shadow console and return its status
  function automatic res_t advance_console(console_op_t op);
    res_t              r;
    int                cls;
    int                rws;
    int                row;
    int                col;
    logic [CELL_W-1:0] blank;
    logic [CELL_W-1:0] v;
    cls   = grid_cols();
    rws   = grid_rows();
    blank = {CH_SPACE, op.fg, op.bg};
    r     = '0;
    clamp_cursor();
    case (op.act)
      ACT_PUT: begin
        if (op.ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (op.ch == CH_RETURN) begin
          cur_col = 0;
        end else if (op.ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_cells[cur_row*GRID_COLS_MAX+cur_col] = blank;
          end
        end else begin
          shadow_cells[cur_row*GRID_COLS_MAX+cur_col] = {op.ch, op.fg, op.bg};
          cur_col++;
          if (cur_col >= cls) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Scroll the active grid up and blank its bottom row
        if (cur_row >= rws) begin
          cur_row = rws - 1;
          for (row = 0; row + 1 < rws; row++)
            for (col = 0; col < cls; col++)
              shadow_cells[row*GRID_COLS_MAX+col] = shadow_cells[(row+1)*GRID_COLS_MAX+col];
          for (col = 0; col < cls; col++)
            shadow_cells[(rws-1)*GRID_COLS_MAX+col] = blank;
          r.scrolled = 1'b1;
        end
      end
      ACT_MOVE: begin
        cur_col = (int'(op.tcol) < cls) ? int'(op.tcol) : cls - 1;
        cur_row = (int'(op.trow) < rws) ? int'(op.trow) : rws - 1;
      end
      ACT_CLEAR: begin
        for (col = 0; col < GRID_COLS_MAX*GRID_ROWS_MAX; col++) shadow_cells[col] = blank;
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        col         = (int'(op.tcol) < cls) ? int'(op.tcol) : cls - 1;
        row         = (int'(op.trow) < rws) ? int'(op.trow) : rws - 1;
        v           = shadow_cells[row*GRID_COLS_MAX+col];
        r.cell_char = v[CELL_W-1:2*COLOR_W];
        r.cell_fg   = v[2*COLOR_W-1:COLOR_W];
        r.cell_bg   = v[COLOR_W-1:0];
      end
    endcase
    r.cursor_col = cur_col[TCOL_W-1:0];
    r.cursor_row = cur_row[TROW_W-1:0];
    return r;
  endfunction

  function automatic void queue_op(action_t act, logic [CHAR_W-1:0] ch,
                                   logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                                   logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow,
                                   bit hold = 1'b0);
    console_op_t op;
    op.act  = act;
    op.ch   = ch;
    op.fg   = fg;
    op.bg   = bg;
    op.tcol = tcol;
    op.trow = trow;
    op.hold = hold;
    op_q.push_back(op);
    results_pending++;
  endfunction

  // Mostly puts with control characters mixed in; targets half in the grid
  function automatic void queue_random_op(bit hold);
    action_t            act;
    logic [CHAR_W-1:0]  ch;
    logic [TCOL_W-1:0]  tcol;
    logic [TROW_W-1:0]  trow;
    int                 pick;
    int                 k;
    pick = $urandom_range(999);
    if (clears_left > 0 && pick < 4) begin
      act = ACT_CLEAR;
      clears_left--;
    end else if (pick < 600) begin
      act = ACT_PUT;
    end else if (pick < 750) begin
      act = ACT_MOVE;
    end else begin
      act = ACT_READ;
    end
    k = $urandom_range(99);
    if (k < 14) ch = CH_NEWLINE;
    else if (k < 20) ch = CH_RETURN;
    else if (k < 30) ch = CH_BACKSPACE;
    else ch = CHAR_W'($urandom_range(255));
    if ($urandom_range(1)) tcol = TCOL_W'($urandom_range(255));
    else tcol = TCOL_W'($urandom_range(grid_cols() - 1));
    if ($urandom_range(1)) trow = TROW_W'($urandom_range(127));
    else trow = TROW_W'($urandom_range(grid_rows() - 1));
    queue_op(act, ch, COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)),
             tcol, trow, hold);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Wait until every result is back, then give the block a few quiet cycles
  task automatic settle();
    while (results_pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Hold one register write until the transfer, then update the shadow
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COLUMNS) cols_reg = data[COLS_REG_W-1:0];
    else if (idx == REG_ROWS) rows_reg = data[ROWS_REG_W-1:0];
    if (idx == REG_COLUMNS || idx == REG_ROWS) clamp_cursor();
    n_reg_writes++;
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] cols_v, input logic [CFG_DATA_W-1:0] rows_v);
    settle();
    write_reg(REG_COLUMNS, cols_v);
    write_reg(REG_ROWS, rows_v);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input logic [CFG_DATA_W-1:0] cols_v,
                              input logic [CFG_DATA_W-1:0] rows_v,
                              input int idle_pct, input int stall_pct,
                              input int count, input int hold_every);
    int i;
    set_grid(cols_v, rows_v);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (i = 0; i < count; i++)
      queue_random_op(hold_every > 0 && (i % hold_every) == hold_every - 1);
  endtask

  // Driver: present the head of the queue, hold it until the transfer
  always @(posedge clk) begin : drive_ops
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        status_q.push_back(advance_console(drv_op));
        n_sent++;
        if (drv_op.act == ACT_CLEAR) n_clears++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (op_q.size() != 0 && !(op_q[0].hold && status_q.size() != 0) &&
            $urandom_range(99) >= sender_idle_pct) begin
          drv_op = op_q.pop_front();
          in_valid      <= 1'b1;
          in_action     <= drv_op.act;
          in_char_code  <= drv_op.ch;
          in_fg_color   <= drv_op.fg;
          in_bg_color   <= drv_op.bg;
          in_target_col <= drv_op.tcol;
          in_target_row <= drv_op.trow;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : watch_results
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_scrolled) n_scrolls++;
        if (status_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          n_errors++;
        end else begin
          want = status_q.pop_front();
          check_field("cursor_col", 16'(want.cursor_col), 16'(out_cursor_col));
          check_field("cursor_row", 16'(want.cursor_row), 16'(out_cursor_row));
          check_field("scrolled", 16'(want.scrolled), 16'(out_scrolled));
          check_field("cell_char", 16'(want.cell_char), 16'(out_cell_char));
          check_field("cell_fg", 16'(want.cell_fg), 16'(out_cell_fg));
          check_field("cell_bg", 16'(want.cell_bg), 16'(out_cell_bg));
          results_pending--;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < GRID_COLS_MAX*GRID_ROWS_MAX; i++)
      shadow_cells[i] = {CH_SPACE, RESET_FG, RESET_BG};
    cols_reg = COLS_REG_W'(COLS_RESET);
    rows_reg = ROWS_REG_W'(ROWS_RESET);
    cur_col  = 0;
    cur_row  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks on the reset-size grid
    sender_idle_pct = 36;
    recv_stall_pct  = 36;
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'd0, 7'd0);
    queue_op(ACT_PUT, 8'h41, 4'hF, 4'h0, 8'd0, 7'd0);
    queue_op(ACT_PUT, 8'hFF, 4'h0, 4'hF, 8'd0, 7'd0);
    queue_op(ACT_PUT, 8'h00, 4'h5, 4'hA, 8'd0, 7'd0);
    queue_op(ACT_PUT, CH_BACKSPACE, 4'h9, 4'h6, 8'd0, 7'd0);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'd2, 7'd0);
    queue_op(ACT_PUT, CH_RETURN, 4'h1, 4'h1, 8'd0, 7'd0);
    // Backspace at column zero leaves everything alone
    queue_op(ACT_PUT, CH_BACKSPACE, 4'hE, 4'hE, 8'd0, 7'd0);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'd1, 7'd0);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7F);
    queue_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7F);
    // Wrap on the last row, then a newline there, both scroll
    queue_op(ACT_PUT, 8'h7E, 4'hC, 4'h3, 8'd0, 7'd0);
    queue_op(ACT_PUT, CH_NEWLINE, 4'h1, 4'h2, 8'd0, 7'd0, 1'b1);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'd79, 7'd22);
    queue_op(ACT_CLEAR, 8'hFF, 4'h3, 4'hC, 8'hFF, 7'h7F);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'd5, 7'd5);

    // Full-size grid through oversize values; unused indexes are ignored
    settle();
    write_reg(REG_COLUMNS, 9'h1FF);
    write_reg(REG_ROWS, 9'h0FF);
    write_reg(2'd2, 9'h1AA);
    write_reg(2'd3, 9'h155);
    cfg_valid <= 1'b0;
    n_settings++;
    queue_op(ACT_MOVE, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7F);
    queue_op(ACT_PUT, 8'h5A, 4'h2, 4'hD, 8'd0, 7'd0);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7E);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7F);

    // Shrink to one cell under the cursor, then grow back
    set_grid(9'h000, 9'h100);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7F);
    set_grid(9'h100, 9'h080);
    queue_op(ACT_READ, 8'h00, 4'h0, 4'h0, 8'hFF, 7'h7E);

    // Random traffic over small, narrow, tall and oversize grids
    random_phase(9'd8,   9'd4,   0,  0,  130, 0);
    random_phase(9'd1,   9'd1,   69, 0,  110, 0);
    random_phase(9'd256, 9'd2,   0,  69, 130, 0);
    random_phase(9'd5,   9'd128, 36, 36, 130, 0);
    random_phase(9'd0,   9'd200, 0,  0,  120, 0);
    random_phase(9'd80,  9'd25,  69, 0,  140, 0);
    random_phase(9'd300, 9'd3,   0,  69, 130, 0);
    random_phase(9'd12,  9'd9,   36, 36, 150, 37);

    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d operations (%0d clears) over %0d grid settings, %0d register writes.",
             n_sent, n_clears, n_settings, n_reg_writes);
    $display("Checked %0d results, %0d of them scrolled the grid.", n_results, n_scrolls);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run: well beyond the clears, scrolls and stalls above
  initial begin : watchdog
    #120_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/tcg_pkg.sv
sv/tcg_cfg_regs.sv
sv/tcg_seq.sv
sv/text_console_cell_grid_core.sv
dv/tb_text_console_cell_grid_core.sv
